// ----- hw/rtl/opp_pkg.sv -----
// ----------------------------------------------------------------------------
// opp_pkg
// Shared types, codes and the relation lookup for the operator-precedence
// parser.
// ----------------------------------------------------------------------------
package opp_pkg;

	// Default sizes
	localparam int TERMINALS_DEF   = 8;
	localparam int STACK_DEPTH_DEF = 16;

	// Configuration register indexes (8-byte spacing)
	localparam logic [1:0] REG_ROWS_LOW  = 2'd0;
	localparam logic [1:0] REG_ROWS_HIGH = 2'd1;
	localparam logic [1:0] REG_TERM_CNT  = 2'd2;
	localparam logic [1:0] REG_END_TOKEN = 2'd3;

	// Reset values
	localparam logic [3:0] TERM_CNT_RST  = 4'd8;
	localparam logic [2:0] END_TOKEN_RST = 3'd7;

	// Precedence relation between stack terminal and input terminal
	typedef enum logic [1:0] {
		REL_BLANK   = 2'd0,
		REL_LESS    = 2'd1,
		REL_EQUAL   = 2'd2,
		REL_GREATER = 2'd3
	} rel_t;

	// Result action codes
	typedef enum logic [2:0] {
		ACT_SHIFT    = 3'd0,
		ACT_REDUCE   = 3'd1,
		ACT_ACCEPT   = 3'd2,
		ACT_BLANK    = 3'd3,
		ACT_OVERFLOW = 3'd4,
		ACT_NOHANDLE = 3'd5,
		ACT_UNKNOWN  = 3'd6
	} action_t;

	// One stack entry: relation mark and terminal
	typedef struct packed {
		rel_t       mark;
		logic [2:0] term;
	} entry_t;

	// Pick the two-bit code for stack terminal s against input terminal t
	function automatic rel_t relation_lookup(
		input logic [63:0] rows_low,
		input logic [63:0] rows_high,
		input logic [2:0]  s,
		input logic [2:0]  t
	);
		logic [63:0] row;
		logic [5:0]  pos;
		row = s[2] ? rows_high : rows_low;
		pos = {s[1:0], t, 1'b0};
		return rel_t'(row[pos +: 2]);
	endfunction

endpackage

// ----- hw/rtl/operator_precedence_parser.sv -----
// ----------------------------------------------------------------------------
// operator_precedence_parser
// Shift-reduce operator-precedence parser. Takes one terminal per transfer,
// walks the parse stack held in a synchronous memory and gives one result
// per shift, reduce, accept or reject.
//
//   channel   direction  handshake                  payload
//   token     in         token_valid / token_stall  token
//   result    out        result_valid / result_stall action, top_terminal,
//                                                   depth, last
//   config    in         APB (psel, penable, ...)   pwdata / prdata
//
// A token is loaded in S_IDLE and compared in S_EVAL; a shift or a reject
// result is registered after these two states. Each reduce takes a compare
// in S_EVAL plus, per popped entry, an S_POP state that issues the stack
// memory read and an S_LOAD state that takes the registered read data as
// the new top. A missing handle ends with a further S_POP visit at the end
// marker. Reset empties the stack at once (pointer to zero); no clearing
// pass. A stalled result holds the parser only when it has a further result
// to hand over; the next token is taken meanwhile.
// ----------------------------------------------------------------------------
module operator_precedence_parser #(
	parameter int TERMINALS   = opp_pkg::TERMINALS_DEF,
	parameter int STACK_DEPTH = opp_pkg::STACK_DEPTH_DEF,
	parameter int DEPTH_W     = $clog2(STACK_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,

	input  logic               token_valid,
	output logic               token_stall,
	input  logic [2:0]         token,

	output logic               result_valid,
	input  logic               result_stall,
	output logic [2:0]         action,
	output logic [2:0]         top_terminal,
	output logic [DEPTH_W-1:0] depth,
	output logic               last
);

	localparam int         AW         = $clog2(STACK_DEPTH);
	localparam logic [3:0] TERM_LIMIT = 4'(TERMINALS);
	localparam logic [DEPTH_W-1:0] SP_FULL = DEPTH_W'(STACK_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_POP,
		S_LOAD
	} state_t;

	// Configuration registers
	logic [63:0] rows_low_q;
	logic [63:0] rows_high_q;
	logic [3:0]  term_cnt_q;
	logic [2:0]  end_token_q;

	// Parser state
	state_t              state_q;
	logic [2:0]          tok_q;
	logic [DEPTH_W-1:0]  sp_q;
	opp_pkg::entry_t     top_q;
	logic                found_q;

	// Result register
	logic                result_valid_q;
	opp_pkg::action_t    result_action_q;
	logic [2:0]          result_top_q;
	logic [DEPTH_W-1:0]  result_depth_q;
	logic                result_last_q;

	// Stack memory
	opp_pkg::entry_t     stack_mem [STACK_DEPTH];
	opp_pkg::entry_t     rd_data_s1;

	logic                out_free;
	logic [2:0]          top_term;
	logic [2:0]          load_term;
	logic                tok_unknown;
	logic                is_accept;
	opp_pkg::rel_t       rel;
	logic                push_en;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;

	// APB register access
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_low_q  <= '0;
			rows_high_q <= '0;
			term_cnt_q  <= opp_pkg::TERM_CNT_RST;
			end_token_q <= opp_pkg::END_TOKEN_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:3])
				opp_pkg::REG_ROWS_LOW:  rows_low_q  <= pwdata;
				opp_pkg::REG_ROWS_HIGH: rows_high_q <= pwdata;
				opp_pkg::REG_TERM_CNT:  term_cnt_q  <= pwdata[3:0];
				opp_pkg::REG_END_TOKEN: end_token_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			opp_pkg::REG_ROWS_LOW:  prdata = rows_low_q;
			opp_pkg::REG_ROWS_HIGH: prdata = rows_high_q;
			opp_pkg::REG_TERM_CNT:  prdata = {60'd0, term_cnt_q};
			opp_pkg::REG_END_TOKEN: prdata = {61'd0, end_token_q};
			default:                prdata = '0;
		endcase
	end

	// Compare the top terminal against the held token
	assign out_free    = !result_valid_q || !result_stall;
	assign top_term    = (sp_q == '0) ? end_token_q : top_q.term;
	assign load_term   = (sp_q == '0) ? end_token_q : rd_data_s1.term;
	assign tok_unknown = ({1'b0, tok_q} >= term_cnt_q) || ({1'b0, tok_q} >= TERM_LIMIT);
	assign is_accept   = (top_term == end_token_q) && (tok_q == end_token_q);
	assign rel         = opp_pkg::relation_lookup(rows_low_q, rows_high_q, top_term, tok_q);

	// Memory port controls
	assign push_en = (state_q == S_EVAL) && out_free && !tok_unknown && !is_accept
		&& (rel == opp_pkg::REL_LESS || rel == opp_pkg::REL_EQUAL) && (sp_q < SP_FULL);
	assign wr_addr = sp_q[AW-1:0];
	assign rd_en   = (state_q == S_POP) && (sp_q > DEPTH_W'(1));
	assign rd_addr = AW'(sp_q - DEPTH_W'(2));

	always_ff @(posedge clk) begin
		if (push_en) begin
			stack_mem[wr_addr] <= '{mark: rel, term: tok_q};
		end
		if (rd_en) begin
			rd_data_s1 <= stack_mem[rd_addr];
		end
	end

	// Parser sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			tok_q           <= '0;
			sp_q            <= '0;
			top_q           <= '0;
			found_q         <= 1'b0;
			result_valid_q  <= 1'b0;
			result_action_q <= opp_pkg::ACT_SHIFT;
			result_top_q    <= '0;
			result_depth_q  <= '0;
			result_last_q   <= 1'b0;
		end else begin
			// drop the result once it is taken
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (token_valid) begin
						tok_q   <= token;
						state_q <= S_EVAL;
					end
				end

				S_EVAL: begin
					if (!tok_unknown && !is_accept && rel == opp_pkg::REL_GREATER) begin
						// start the handle walk, nothing to hand over yet
						state_q <= S_POP;
					end else if (out_free) begin
						result_valid_q <= 1'b1;
						result_last_q  <= 1'b1;
						result_top_q   <= end_token_q;
						result_depth_q <= '0;
						state_q        <= S_IDLE;
						if (tok_unknown) begin
							sp_q            <= '0;
							result_action_q <= opp_pkg::ACT_UNKNOWN;
						end else if (is_accept) begin
							sp_q            <= '0;
							result_action_q <= opp_pkg::ACT_ACCEPT;
						end else if (rel == opp_pkg::REL_BLANK) begin
							sp_q            <= '0;
							result_action_q <= opp_pkg::ACT_BLANK;
						end else if (sp_q >= SP_FULL) begin
							sp_q            <= '0;
							result_action_q <= opp_pkg::ACT_OVERFLOW;
						end else begin
							sp_q            <= sp_q + DEPTH_W'(1);
							top_q           <= '{mark: rel, term: tok_q};
							result_action_q <= opp_pkg::ACT_SHIFT;
							result_top_q    <= tok_q;
							result_depth_q  <= sp_q + DEPTH_W'(1);
						end
					end
				end

				S_POP: begin
					if (sp_q == '0) begin
						// walked down to the end marker without a less mark
						if (out_free) begin
							result_valid_q  <= 1'b1;
							result_action_q <= opp_pkg::ACT_NOHANDLE;
							result_top_q    <= end_token_q;
							result_depth_q  <= '0;
							result_last_q   <= 1'b1;
							state_q         <= S_IDLE;
						end
					end else begin
						found_q <= (top_q.mark == opp_pkg::REL_LESS);
						sp_q    <= sp_q - DEPTH_W'(1);
						state_q <= S_LOAD;
					end
				end

				S_LOAD: begin
					// take the entry below as the new top
					if (sp_q != '0) begin
						top_q <= rd_data_s1;
					end
					if (found_q) begin
						if (out_free) begin
							result_valid_q  <= 1'b1;
							result_action_q <= opp_pkg::ACT_REDUCE;
							result_top_q    <= load_term;
							result_depth_q  <= sp_q;
							result_last_q   <= 1'b0;
							state_q         <= S_EVAL;
						end
					end else begin
						state_q <= S_POP;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign token_stall  = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign action       = result_action_q;
	assign top_terminal = result_top_q;
	assign depth        = result_depth_q;
	assign last         = result_last_q;

`ifndef ASSERT_OFF
	// The stack pointer never passes the stack size
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_FULL)
		else $error("stack pointer beyond stack size");

	// Accept and rejects end the token with an empty stack
	a_final_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && action != opp_pkg::ACT_SHIFT && action != opp_pkg::ACT_REDUCE
		|-> depth == '0 && last && top_terminal == end_token_q)
		else $error("final result without empty stack");

	// A reduce is never the last result of a token
	a_reduce_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && action == opp_pkg::ACT_REDUCE |-> !last)
		else $error("reduce marked as last");

	// A shift leaves the pushed token on a non-empty stack
	a_shift_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && action == opp_pkg::ACT_SHIFT |-> depth != '0 && last)
		else $error("shift with empty stack");
`endif

endmodule
